>>> rtl/pmm_pkg.sv
// Shared types and constants of the programmable Mealy machine.
package pmm_pkg;

  localparam int CMD_W       = 2;
  localparam int SYM_FIELD_W = 8;
  localparam int STATE_W     = 4;
  localparam int COL_FIELD_W = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int QUEUE_DEPTH = 2;

  // Command codes of an input item.
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TABLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ALPHA = 2'd3;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_EMIT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_STATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 1'd1;

  typedef enum logic [1:0] {
    OP_RUN,
    OP_BEGIN,
    OP_TABLE,
    OP_ALPHA
  } op_kind_t;

  // A classified item as it waits between the front and the back.
  typedef struct packed {
    op_kind_t                 kind;
    logic                     wr_ok;
    logic [SYM_FIELD_W-1:0]   symbol;
    logic [STATE_W-1:0]       row_state;
    logic [COL_FIELD_W-1:0]   column_index;
    logic [STATE_W-1:0]       target_state;
    logic [SYM_FIELD_W-1:0]   emit_symbol;
  } op_t;

  // Handshake between the queue and the back part.
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

>>> rtl/pmm_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface pmm_in_if;
  logic                                valid;
  logic                                ready;
  logic [pmm_pkg::CMD_W-1:0]           cmd;
  logic [pmm_pkg::SYM_FIELD_W-1:0]     symbol;
  logic [pmm_pkg::STATE_W-1:0]         row_state;
  logic [pmm_pkg::COL_FIELD_W-1:0]     column_index;
  logic [pmm_pkg::STATE_W-1:0]         target_state;
  logic [pmm_pkg::SYM_FIELD_W-1:0]     emit_symbol;

  modport source (output valid, cmd, symbol, row_state, column_index, target_state,
                  emit_symbol, input ready);
  modport sink (input valid, cmd, symbol, row_state, column_index, target_state,
                emit_symbol, output ready);
endinterface

interface pmm_out_if;
  logic                                valid;
  logic                                ready;
  logic [pmm_pkg::SYM_FIELD_W-1:0]     out_symbol;
  logic [pmm_pkg::STATUS_W-1:0]        status;
  logic [pmm_pkg::STATE_W-1:0]         present_state;

  modport source (output valid, out_symbol, status, present_state, input ready);
  modport sink (input valid, out_symbol, status, present_state, output ready);
endinterface

interface pmm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pmm_pkg::CFG_IDX_W-1:0]       index;
  logic [pmm_pkg::CFG_DATA_W-1:0]      value;

  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

>>> rtl/pmm_front.sv
// Front part: accepts input items, decodes the command and checks write ranges.
module pmm_front #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8
) (
  pmm_in_if.sink         in_if,
  input  logic           q_full,
  output logic           q_push,
  output pmm_pkg::op_t   q_op
);
  import pmm_pkg::*;

  always_comb begin
    in_if.ready = !q_full;
    q_push      = in_if.valid && !q_full;

    q_op.symbol       = in_if.symbol;
    q_op.row_state    = in_if.row_state;
    q_op.column_index = in_if.column_index;
    q_op.target_state = in_if.target_state;
    q_op.emit_symbol  = in_if.emit_symbol;

    unique case (in_if.cmd)
      CMD_RUN: begin
        q_op.kind  = OP_RUN;
        q_op.wr_ok = 1'b0;
      end
      CMD_BEGIN: begin
        q_op.kind  = OP_BEGIN;
        q_op.wr_ok = 1'b0;
      end
      CMD_TABLE: begin
        q_op.kind  = OP_TABLE;
        q_op.wr_ok = (int'(in_if.row_state) < MAX_STATES) &&
                     (int'(in_if.column_index) < MAX_SYMBOLS);
      end
      CMD_ALPHA: begin
        q_op.kind  = OP_ALPHA;
        q_op.wr_ok = int'(in_if.column_index) < MAX_SYMBOLS;
      end
      default: begin
        q_op.kind  = OP_RUN;
        q_op.wr_ok = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/pmm_queue.sv
// Short queue of classified items between the front and the back part.
module pmm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pmm_pkg::op_t      push_op,
  output logic              full,
  input  logic              pop,
  output pmm_pkg::q_head_t  head
);
  import pmm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full       = count_r == CNT_W'(QUEUE_DEPTH);
    head.valid = count_r != '0;
    head.op    = slot_r[rp_r];
    do_push    = push && !full;
    do_pop     = pop && head.valid;

    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_op;
    end
  end

endmodule

>>> rtl/pmm_back.sv
// Back part: alphabet match, transition table, machine state and result register.
module pmm_back #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8,
  parameter int SYMBOL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  pmm_cfg_if.sink           cfg_if,
  input  pmm_pkg::q_head_t  head,
  output logic              q_pop,
  pmm_out_if.source         out_if
);
  import pmm_pkg::*;

  localparam int SYM_W  = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;
  localparam int ROWS   = (MAX_STATES < (1 << STATE_W)) ? MAX_STATES : (1 << STATE_W);
  localparam int COLS   = (MAX_SYMBOLS < (1 << COL_FIELD_W)) ? MAX_SYMBOLS
                                                               : (1 << COL_FIELD_W);
  localparam int IDX_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int DEPTH  = ROWS * COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = STATE_W + SYM_W;

  function automatic logic [STATE_W-1:0] clamp_state(input logic [STATE_W-1:0] s);
    return (int'(s) >= MAX_STATES) ? STATE_W'(MAX_STATES - 1) : s;
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] start_r;
  logic [CFG_DATA_W-1:0] count_r;

  // Stores.
  logic [SYM_W-1:0]   alpha_r [COLS];
  logic [ENTRY_W-1:0] table_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_r;

  // Machine state and result stage.
  logic [STATE_W-1:0]  cs_r, cs_nxt, cs_eff;
  logic                aborted_r, aborted_nxt;
  logic                s2_valid_r, s2_valid_nxt;
  logic                s2_hit_r, s2_hit_nxt;
  logic [STATUS_W-1:0] s2_status_r, s2_status_nxt;
  logic [STATE_W-1:0]  s2_state_r, s2_state_nxt;

  logic                s1_fire;
  logic                hit;
  logic [IDX_W-1:0]    idx;
  logic                tbl_we, tbl_re, alpha_we;
  logic [AW-1:0]       tbl_addr;
  logic [STATE_W-1:0]  rd_next;
  logic [SYM_W-1:0]    rd_emit;

  assign rd_next = rd_r[ENTRY_W-1 -: STATE_W];
  assign rd_emit = rd_r[SYM_W-1:0];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      count_r <= CFG_DATA_W'(1);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_START_STATE:  start_r <= cfg_if.value;
        REG_SYMBOL_COUNT: count_r <= cfg_if.value;
        default: ;
      endcase
    end
  end

  // Parallel alphabet compare; the lowest matching position wins.
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int k = COLS - 1; k >= 0; k--) begin
      if ((k < int'(count_r)) && (alpha_r[k] == head.op.symbol[SYM_W-1:0])) begin
        hit = 1'b1;
        idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    cs_eff  = (s2_valid_r && s2_hit_r) ? clamp_state(rd_next) : cs_r;
    s1_fire = head.valid && (!s2_valid_r || out_if.ready);
    q_pop   = s1_fire;

    cs_nxt        = cs_eff;
    aborted_nxt   = aborted_r;
    s2_valid_nxt  = s2_valid_r && !out_if.ready;
    s2_hit_nxt    = s2_hit_r;
    s2_status_nxt = s2_status_r;
    s2_state_nxt  = s2_state_r;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    alpha_we      = 1'b0;

    if (head.op.kind == OP_RUN) begin
      tbl_addr = AW'(int'(cs_eff) * COLS + int'(idx));
    end else begin
      tbl_addr = AW'(int'(head.op.row_state) * COLS + int'(head.op.column_index));
    end

    if (s1_fire) begin
      s2_valid_nxt  = 1'b1;
      s2_hit_nxt    = 1'b0;
      s2_status_nxt = ST_DONE;
      s2_state_nxt  = cs_eff;
      unique case (head.op.kind)
        OP_RUN: begin
          if (aborted_r) begin
            s2_status_nxt = ST_IGNORED;
          end else if (hit) begin
            s2_hit_nxt    = 1'b1;
            s2_status_nxt = ST_EMIT;
            tbl_re        = 1'b1;
          end else begin
            aborted_nxt   = 1'b1;
            s2_status_nxt = ST_ABORT;
          end
        end
        OP_BEGIN: begin
          cs_nxt       = clamp_state(start_r);
          aborted_nxt  = 1'b0;
          s2_state_nxt = clamp_state(start_r);
        end
        OP_TABLE: tbl_we   = head.op.wr_ok;
        OP_ALPHA: alpha_we = head.op.wr_ok;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r       <= '0;
      aborted_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_hit_r   <= 1'b0;
    end else begin
      cs_r       <= cs_nxt;
      aborted_r  <= aborted_nxt;
      s2_valid_r <= s2_valid_nxt;
      s2_hit_r   <= s2_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_status_r <= s2_status_nxt;
    s2_state_r  <= s2_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[tbl_addr] <= {head.op.target_state, head.op.emit_symbol[SYM_W-1:0]};
    end
    if (tbl_re) begin
      rd_r <= table_mem[tbl_addr];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < COLS; k++) begin
      if (alpha_we && (int'(head.op.column_index) == k)) begin
        alpha_r[k] <= head.op.symbol[SYM_W-1:0];
      end
    end
  end

  always_comb begin
    out_if.valid         = s2_valid_r;
    out_if.status        = s2_status_r;
    out_if.out_symbol    = s2_hit_r ? SYM_FIELD_W'(rd_emit) : '0;
    out_if.present_state = s2_hit_r ? clamp_state(rd_next) : s2_state_r;
  end

endmodule

>>> rtl/programmable_mealy_machine.sv
// Top level of the programmable Mealy machine: front, item queue and back part.
// An accepted item passes the item queue, then the result register. Throughput: one
// item per cycle while out_if takes each result item; the loop from the registered
// table read through the state clamp into the next table address sets that rate.
// Reset (rst_n low, synchronous) clears the queue, the state, the abort flag and the
// result stage and loads start_state 0 and symbol_count 1; the stores stay unwritten.

module programmable_mealy_machine #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8,
  parameter int SYMBOL_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pmm_in_if.sink     in_if,
  pmm_cfg_if.sink    cfg_if,
  pmm_out_if.source  out_if
);
  import pmm_pkg::*;

  // The front decodes each item as it is accepted and pushes it into the queue.
  // The queue lets input acceptance go on while the result stage waits on out_if.
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  op_t     q_op;
  q_head_t q_head;

  pmm_front #(
    .MAX_STATES (MAX_STATES),
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .in_if (in_if),
    .q_full(q_full),
    .q_push(q_push),
    .q_op  (q_op)
  );

  pmm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .push_op(q_op),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head)
  );

  // The back part runs the machine: it matches run symbols against the alphabet,
  // reads the transition table and holds each result item until it is taken.
  pmm_back #(
    .MAX_STATES (MAX_STATES),
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_if(cfg_if),
    .head  (q_head),
    .q_pop (q_pop),
    .out_if(out_if)
  );

`ifndef ASSERT_OFF
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("item pushed into a full queue");

  // Only an emitted result carries a nonzero output symbol.
  a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != ST_EMIT)) |-> (out_if.out_symbol == '0))
    else $error("nonzero output symbol without emit status");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

  // A popped item always comes from a non-empty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("back part popped an empty queue");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench of the programmable Mealy machine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmm_pkg::*;

  // The block is built with its default sizes, and the mirror below uses the same ones.
  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 8;

  // The result of an item shows up once it has passed the queue and the result stage, so
  // SETTLE_CYCLES spare cycles let the pipeline settle before a register write or the end.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_SEGMENT = 220;
  localparam int SEGMENTS = 6;

  // Register settings of the random segments, segment 0 in the low nibble. They include
  // a symbol count of zero (no run matches), the saturating count of 15 and the full
  // count of 8, together with both extremes of the start state.
  localparam logic [SEGMENTS*CFG_DATA_W-1:0] START_PLAN =
    {4'd0, 4'd15, 4'd9, 4'd0, 4'd15, 4'd3};
  localparam logic [SEGMENTS*CFG_DATA_W-1:0] COUNT_PLAN =
    {4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd8};

  typedef struct packed {
    logic [SYM_FIELD_W-1:0] out_symbol;
    logic [STATUS_W-1:0]    status;
    logic [STATE_W-1:0]     present_state;
  } mealy_result_t;

  // One input item. When fixed is set the expected result is the one typed into the
  // item itself rather than the one the mirror works out.
  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [SYM_FIELD_W-1:0] symbol;
    logic [STATE_W-1:0]     row_state;
    logic [COL_FIELD_W-1:0] column_index;
    logic [STATE_W-1:0]     target_state;
    logic [SYM_FIELD_W-1:0] emit_symbol;
    logic                   fixed;
    logic [SYM_FIELD_W-1:0] fixed_symbol;
    logic [STATUS_W-1:0]    fixed_status;
    logic [STATE_W-1:0]     fixed_state;
  } mealy_item_t;

  localparam int DIRECTED_ROWS = 15;

  // Directed opening, run at the reset settings (start state 0, one alphabet entry in
  // use). Every entry that a run reads here is written by an earlier row.
  mealy_item_t directed_rows [DIRECTED_ROWS] = '{
    // A begin right after reset lands in start state 0.
    '{CMD_BEGIN, 8'h00, 4'h0, 3'd0, 4'h0, 8'h00, 1'b1, 8'h00, ST_DONE, 4'h0},
    // Load alphabet entry 0 and the two table entries the runs below walk through.
    '{CMD_ALPHA, 8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b1, 8'h00, ST_DONE, 4'h0},
    '{CMD_TABLE, 8'h00, 4'h0, 3'd0, 4'hF, 8'hA5, 1'b1, 8'h00, ST_DONE, 4'h0},
    '{CMD_TABLE, 8'h00, 4'hF, 3'd0, 4'h0, 8'h5A, 1'b1, 8'h00, ST_DONE, 4'h0},
    // Two matching runs: state 0 goes to 15 and back to 0.
    '{CMD_RUN,   8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 8'h00, ST_DONE, 4'h0},
    '{CMD_RUN,   8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 8'h00, ST_DONE, 4'h0},
    // An unknown symbol aborts the string and leaves the state alone.
    '{CMD_RUN,   8'h00, 4'h0, 3'd0, 4'h0, 8'h00, 1'b1, 8'h00, ST_ABORT, 4'h0},
    // Once aborted, even a known symbol is ignored.
    '{CMD_RUN,   8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b1, 8'h00, ST_IGNORED, 4'h0},
    // Writes with index, target and emit at top values while the string is aborted.
    '{CMD_TABLE, 8'hFF, 4'hF, 3'd7, 4'hF, 8'hFF, 1'b1, 8'h00, ST_DONE, 4'h0},
    '{CMD_ALPHA, 8'h00, 4'hF, 3'd7, 4'hF, 8'hFF, 1'b1, 8'h00, ST_DONE, 4'h0},
    // A begin clears the abort flag.
    '{CMD_BEGIN, 8'hFF, 4'hF, 3'd7, 4'hF, 8'hFF, 1'b1, 8'h00, ST_DONE, 4'h0},
    '{CMD_RUN,   8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 8'h00, ST_DONE, 4'h0},
    // Rewrite the entry of the state we sit in so that it loops on itself.
    '{CMD_TABLE, 8'h00, 4'hF, 3'd0, 4'hF, 8'h00, 1'b1, 8'h00, ST_DONE, 4'hF},
    '{CMD_RUN,   8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 8'h00, ST_DONE, 4'h0},
    '{CMD_RUN,   8'hFF, 4'h0, 3'd0, 4'h0, 8'h00, 1'b0, 8'h00, ST_DONE, 4'h0}
  };

  logic clk;
  logic rst_n;
  logic result_ready = 1'b0;

  pmm_in_if  in_if();
  pmm_cfg_if cfg_if();
  pmm_out_if out_if();

  assign out_if.ready = result_ready;

  programmable_mealy_machine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  // Mirror of the machine: registers, string state and both stores.
  logic [CFG_DATA_W-1:0]  start_reg;
  logic [CFG_DATA_W-1:0]  count_reg;
  logic [STATE_W-1:0]     machine_state;
  logic                   string_aborted;
  logic [SYM_FIELD_W-1:0] alphabet [NUM_SYMBOLS];
  logic [STATE_W-1:0]     next_table [NUM_STATES][NUM_SYMBOLS];
  logic [SYM_FIELD_W-1:0] emit_table [NUM_STATES][NUM_SYMBOLS];

  mealy_result_t steps_due[$];
  mealy_item_t   drv_item;
  int            mismatches = 0;
  int            cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  // Works out the result of one item and moves the mirror along. With 16 states and a
  // 4-bit state field, no start state or stored target can fall out of range, so no
  // clamping is needed.
  function automatic mealy_result_t mealy_step(input logic [CMD_W-1:0] cmd,
                                               input logic [SYM_FIELD_W-1:0] sym,
                                               input logic [STATE_W-1:0] row,
                                               input logic [COL_FIELD_W-1:0] col,
                                               input logic [STATE_W-1:0] tgt,
                                               input logic [SYM_FIELD_W-1:0] emit);
    mealy_result_t r;
    int n;
    int k;
    int hit_col;
    r.out_symbol = '0;
    r.status = ST_DONE;
    hit_col = -1;
    case (cmd)
      CMD_RUN: begin
        if (string_aborted) begin
          r.status = ST_IGNORED;
        end else begin
          // Counts above the alphabet size saturate; zero matches nothing.
          n = (count_reg > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(count_reg);
          // Scan downward so that the lowest matching entry is the one kept.
          for (k = n - 1; k >= 0; k--) begin
            if (alphabet[k] == sym) hit_col = k;
          end
          if (hit_col >= 0) begin
            r.out_symbol = emit_table[machine_state][hit_col];
            r.status = ST_EMIT;
            machine_state = next_table[machine_state][hit_col];
          end else begin
            string_aborted = 1'b1;
            r.status = ST_ABORT;
          end
        end
      end
      CMD_BEGIN: begin
        machine_state = start_reg;
        string_aborted = 1'b0;
      end
      CMD_TABLE: begin
        next_table[row][col] = tgt;
        emit_table[row][col] = emit;
      end
      default: begin
        alphabet[col] = sym;
      end
    endcase
    r.present_state = machine_state;
    return r;
  endfunction

  // Random item. Most items are runs on symbols of the loaded alphabet so that strings
  // get long; the rest are begins, table and alphabet rewrites, and stray symbols that
  // usually abort. Every alphabet and table entry is loaded before the first random
  // item, so no run can read an entry that was never written.
  function automatic mealy_item_t random_item();
    mealy_item_t item;
    int unsigned pick;
    int lim;
    item = '0;
    item.symbol       = SYM_FIELD_W'($urandom_range(255));
    item.row_state    = STATE_W'($urandom_range(NUM_STATES - 1));
    item.column_index = COL_FIELD_W'($urandom_range(NUM_SYMBOLS - 1));
    item.target_state = STATE_W'($urandom_range(NUM_STATES - 1));
    item.emit_symbol  = SYM_FIELD_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 72) begin
      item.cmd = CMD_RUN;
      lim = (count_reg == 0 || count_reg > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(count_reg);
      if ($urandom_range(9) != 0) item.symbol = alphabet[$urandom_range(lim - 1)];
    end else if (pick < 82) begin
      item.cmd = CMD_BEGIN;
    end else if (pick < 92) begin
      item.cmd = CMD_TABLE;
    end else begin
      item.cmd = CMD_ALPHA;
      // Now and then duplicate another entry so that the lowest-index rule matters.
      if ($urandom_range(3) == 0) item.symbol = alphabet[$urandom_range(NUM_SYMBOLS - 1)];
    end
    return item;
  endfunction

  // Presents one item, with random idle cycles in front of it, and returns at the edge
  // that takes it. The valid is not lowered here, so back-to-back items keep it high.
  task automatic send_item(input mealy_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= item.cmd;
    in_if.symbol       <= item.symbol;
    in_if.row_state    <= item.row_state;
    in_if.column_index <= item.column_index;
    in_if.target_state <= item.target_state;
    in_if.emit_symbol  <= item.emit_symbol;
    drv_item           <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stops sending and waits until every pending result has come back and the block
  // has had time to settle.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (steps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.value <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] start_val,
                              input logic [CFG_DATA_W-1:0] count_val);
    write_reg(REG_START_STATE, start_val);
    write_reg(REG_SYMBOL_COUNT, count_val);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random with the rate of the current idling mode.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** programmable_mealy_machine: FAILED **");
      $finish;
    end
  end

  // One process sees every handshake of an edge in a fixed order: register writes,
  // then taken items, then results. All values are read as they stood at the edge.
  always @(posedge clk) begin : watch
    mealy_result_t want;
    if (!rst_n) begin
      start_reg      = '0;
      count_reg      = 4'd1;
      machine_state  = '0;
      string_aborted = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_START_STATE:  start_reg = cfg_if.value;
          REG_SYMBOL_COUNT: count_reg = cfg_if.value;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        want = mealy_step(in_if.cmd, in_if.symbol, in_if.row_state, in_if.column_index,
                          in_if.target_state, in_if.emit_symbol);
        if (drv_item.fixed) begin
          want = '{drv_item.fixed_symbol, drv_item.fixed_status, drv_item.fixed_state};
        end
        steps_due.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        if (steps_due.size() == 0) begin
          $error("result item with nothing pending: status %0d, state %0d",
                 out_if.status, out_if.present_state);
          mismatches++;
        end else begin
          want = steps_due.pop_front();
          if (out_if.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %0h, got %0h", want.out_symbol, out_if.out_symbol);
            mismatches++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            mismatches++;
          end
          if (out_if.present_state !== want.present_state) begin
            $error("present_state: expected %0d, got %0d",
                   want.present_state, out_if.present_state);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int seg;
    int row;
    int col;
    mealy_item_t item;
    logic [SYM_FIELD_W-1:0] loaded_syms [NUM_SYMBOLS];

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_RUN;
    in_if.symbol       <= '0;
    in_if.row_state    <= '0;
    in_if.column_index <= '0;
    in_if.target_state <= '0;
    in_if.emit_symbol  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_START_STATE;
    cfg_if.value       <= '0;
    drv_item           <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // First idling mode: the sender idles now and then, the receiver most of the time.
    send_idle_pct = 16;
    recv_idle_pct = 68;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_item(directed_rows[row]);
    end

    // Load every alphabet and table entry with random content before anything random
    // runs. A quarter of the alphabet entries repeat an earlier one, taken from the
    // local list of loaded symbols so the choice never depends on the mirror's timing.
    for (col = 0; col < NUM_SYMBOLS; col++) begin
      item = '0;
      item.cmd = CMD_ALPHA;
      item.column_index = COL_FIELD_W'(col);
      item.symbol = (col > 0 && $urandom_range(3) == 0)
                    ? loaded_syms[$urandom_range(col - 1)]
                    : SYM_FIELD_W'($urandom_range(255));
      loaded_syms[col] = item.symbol;
      send_item(item);
    end
    for (row = 0; row < NUM_STATES; row++) begin
      for (col = 0; col < NUM_SYMBOLS; col++) begin
        item = '0;
        item.cmd = CMD_TABLE;
        item.row_state = STATE_W'(row);
        item.column_index = COL_FIELD_W'(col);
        item.target_state = STATE_W'($urandom_range(NUM_STATES - 1));
        item.emit_symbol = SYM_FIELD_W'($urandom_range(255));
        send_item(item);
      end
    end

    // Random segments, two per idling mode. Each one starts from an idle block, where
    // the registers get their next setting. The running string is carried across, so a
    // write in the middle of a string is covered too.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      program_regs(START_PLAN[seg*CFG_DATA_W +: CFG_DATA_W],
                   COUNT_PLAN[seg*CFG_DATA_W +: CFG_DATA_W]);
      repeat (ITEMS_PER_SEGMENT) send_item(random_item());
    end

    drain_results();
    if (mismatches == 0) begin
      $display("** programmable_mealy_machine: PASSED **");
    end else begin
      $display("** programmable_mealy_machine: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pmm_pkg.sv
rtl/pmm_if.sv
rtl/pmm_front.sv
rtl/pmm_queue.sv
rtl/pmm_back.sv
rtl/programmable_mealy_machine.sv
tb/tb.sv
